### rtl/tsl_pkg.sv
`timescale 1ns / 1ps
// tsl_pkg: shared types and constants for the strip-to-list converter
// no dependencies

package tsl_pkg;

  localparam int INDEX_BITS_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int NARROW_BITS     = 16;
  localparam int FIELD_BITS      = 32;

  // one list triangle as it travels from front to back
  typedef struct packed {
    logic [FIELD_BITS-1:0] first_vertex;
    logic [FIELD_BITS-1:0] second_vertex;
    logic [FIELD_BITS-1:0] third_vertex;
    logic [FIELD_BITS-1:0] triangles_emitted;
  } tri_t;

  // front to queue push request
  typedef struct packed {
    logic valid;
    tri_t data;
  } push_t;

endpackage

### rtl/tsl_front.sv
`timescale 1ns / 1ps
// tsl_front: accepts strip indices, tracks strip state and forms list triangles
// depends on tsl_pkg

module tsl_front #(
  parameter int INDEX_BITS = tsl_pkg::INDEX_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tsl_pkg::FIELD_BITS-1:0] vertex_index,
  input  logic                         strip_begin,
  input  logic                         q_full,
  output tsl_pkg::push_t               push
);

  localparam logic [INDEX_BITS-1:0] NARROW_MASK =
    INDEX_BITS'({tsl_pkg::NARROW_BITS{1'b1}});

  logic                              wide_indices;
  logic [INDEX_BITS-1:0]             older_index;
  logic [INDEX_BITS-1:0]             newer_index;
  logic [1:0]                        indices_seen;
  logic                              odd_triangle;
  logic [tsl_pkg::FIELD_BITS-1:0]    emitted_count;

  logic                              accept;
  logic [INDEX_BITS-1:0]             cur;
  logic [1:0]                        seen_eff;
  logic                              odd_eff;
  logic [tsl_pkg::FIELD_BITS-1:0]    cnt_eff;
  logic                              closes;
  logic                              degenerate;
  logic [tsl_pkg::FIELD_BITS-1:0]    cnt_inc;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cur = vertex_index[INDEX_BITS-1:0];
    if (!wide_indices) begin
      cur = cur & NARROW_MASK;
    end
    // a begin flag restarts the strip before this index is taken
    seen_eff   = strip_begin ? 2'd0 : indices_seen;
    odd_eff    = strip_begin ? 1'b0 : odd_triangle;
    cnt_eff    = strip_begin ? '0 : emitted_count;
    closes     = (seen_eff == 2'd2);
    degenerate = (older_index == newer_index) || (newer_index == cur) ||
                 (older_index == cur);
    cnt_inc    = cnt_eff + 1'b1;
  end

  always_comb begin
    push.valid                  = accept && closes && !degenerate;
    push.data.first_vertex      = odd_eff ? tsl_pkg::FIELD_BITS'(newer_index)
                                          : tsl_pkg::FIELD_BITS'(older_index);
    push.data.second_vertex     = odd_eff ? tsl_pkg::FIELD_BITS'(older_index)
                                          : tsl_pkg::FIELD_BITS'(newer_index);
    push.data.third_vertex      = tsl_pkg::FIELD_BITS'(cur);
    push.data.triangles_emitted = cnt_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_indices  <= 1'b0;
      older_index   <= '0;
      newer_index   <= '0;
      indices_seen  <= 2'd0;
      odd_triangle  <= 1'b0;
      emitted_count <= '0;
    end else begin
      if (cfg_we) begin
        wide_indices <= cfg_wdata;
      end
      if (accept) begin
        older_index <= newer_index;
        newer_index <= cur;
        if (!closes) begin
          indices_seen  <= seen_eff + 2'd1;
          odd_triangle  <= odd_eff;
          emitted_count <= cnt_eff;
        end else begin
          // dropped triangles still flip the parity
          indices_seen  <= seen_eff;
          odd_triangle  <= !odd_eff;
          emitted_count <= degenerate ? cnt_eff : cnt_inc;
        end
      end
    end
  end

  a_no_degenerate: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> (push.data.first_vertex != push.data.second_vertex) &&
                   (push.data.second_vertex != push.data.third_vertex) &&
                   (push.data.first_vertex != push.data.third_vertex))
    else $error("degenerate triangle pushed");

  a_begin_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && strip_begin) |=> (indices_seen == 2'd1) && (emitted_count == '0))
    else $error("strip begin did not restart state");

endmodule

### rtl/tsl_queue.sv
`timescale 1ns / 1ps
// tsl_queue: small fifo of list triangles between front and back
// depends on tsl_pkg

module tsl_queue #(
  parameter int QUEUE_DEPTH = tsl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  tsl_pkg::push_t push,
  input  logic           pop,
  output logic           full,
  output logic           q_valid,
  output tsl_pkg::tri_t  q_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  tsl_pkg::tri_t    mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_data  = mem[rd_ptr];
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      // pointers wrap at the depth, which need not be a power of two
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push.valid && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push.valid && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !full)
    else $error("push into full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

### rtl/tsl_back.sv
`timescale 1ns / 1ps
// tsl_back: output register that drains the triangle queue onto the result port
// depends on tsl_pkg

module tsl_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  tsl_pkg::tri_t                  q_data,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tsl_pkg::FIELD_BITS-1:0] first_vertex,
  output logic [tsl_pkg::FIELD_BITS-1:0] second_vertex,
  output logic [tsl_pkg::FIELD_BITS-1:0] third_vertex,
  output logic [tsl_pkg::FIELD_BITS-1:0] triangles_emitted
);

  tsl_pkg::tri_t held;

  // load when the register is empty or its transfer completes this cycle
  assign pop = q_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      held <= q_data;
    end
  end

  assign first_vertex      = held.first_vertex;
  assign second_vertex     = held.second_vertex;
  assign third_vertex      = held.third_vertex;
  assign triangles_emitted = held.triangles_emitted;

endmodule

### rtl/triangle_strip_to_list_top.sv
`timescale 1ns / 1ps
// path: the triangle of a closing index is written into the queue when the index is accepted,
// then loaded into the output register once that register is empty or its transfer completes
// throughput: one index per cycle; in_stall rises only while the triangle queue is full
// reset: synchronous, clears strip state, selects 16-bit indices, empties queue and output
// depends on tsl_pkg, tsl_front, tsl_queue, tsl_back

module triangle_strip_to_list_top #(
  parameter int INDEX_BITS  = tsl_pkg::INDEX_BITS_DEF,
  parameter int QUEUE_DEPTH = tsl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tsl_pkg::FIELD_BITS-1:0] vertex_index,
  input  logic                           strip_begin,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tsl_pkg::FIELD_BITS-1:0] first_vertex,
  output logic [tsl_pkg::FIELD_BITS-1:0] second_vertex,
  output logic [tsl_pkg::FIELD_BITS-1:0] third_vertex,
  output logic [tsl_pkg::FIELD_BITS-1:0] triangles_emitted
);

  tsl_pkg::push_t push;
  tsl_pkg::tri_t  q_data;
  logic           q_full;
  logic           q_valid;
  logic           pop;

  tsl_front #(
    .INDEX_BITS(INDEX_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .vertex_index (vertex_index),
    .strip_begin  (strip_begin),
    .q_full       (q_full),
    .push         (push)
  );

  tsl_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .pop     (pop),
    .full    (q_full),
    .q_valid (q_valid),
    .q_data  (q_data)
  );

  tsl_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_data            (q_data),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .first_vertex      (first_vertex),
    .second_vertex     (second_vertex),
    .third_vertex      (third_vertex),
    .triangles_emitted (triangles_emitted)
  );

endmodule
